FILE: rtl/gps_pkg.sv
// Shared constants for the grid path search block.
package gps_pkg;

    localparam int GRID_W_DEF = 32;
    localparam int GRID_H_DEF = 32;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;

    // which neighbour of its parent a tile is
    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_DOWN  = 2'd2;
    localparam logic [1:0] NB_LEFT  = 2'd3;

endpackage

FILE: rtl/grid_path_search.sv
// Grid path search: map writes, direction reads and greedy best-first searches.
// Write and read: the access passes through S_WRMOD or S_RDDIR, then S_FIN loads the
// result; a new input transfer is taken only in S_IDLE. A search clears the flags,
// then per expansion scans all tiles, closes the best open tile and visits up to four
// neighbours, then traces the path back. A result held by out_ready stalls the next
// transfer. After reset a clearing pass zeroes the memory; no input is taken until it ends.
module grid_path_search
    import gps_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [4:0]  tile_x,
    input  logic [4:0]  tile_y,
    input  logic        is_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  direction,
    output logic        path_found
);

    localparam int N    = GRID_W * GRID_H;
    localparam int AW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);
    localparam int XW   = $clog2(GRID_W);
    localparam int YW   = $clog2(GRID_H);
    localparam int MXY  = (XW > YW) ? XW : YW;
    localparam int PW   = ((MXY > 5) ? MXY : 5) + 1;
    localparam int DXM  = (GRID_W - 1 > 31) ? GRID_W - 1 : 31;
    localparam int DYM  = (GRID_H - 1 > 31) ? GRID_H - 1 : 31;
    localparam int CW   = $clog2(DXM + DYM + 2);

    typedef struct packed {
        logic          free_b;
        logic          open_b;
        logic          closed_b;
        logic [CW-1:0] cost;
        logic [1:0]    pdir;
        logic [2:0]    dir;
    } word_t;

    localparam int DW = $bits(word_t);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_WRMOD, S_RDDIR, S_SCLR, S_SCAN, S_CLOSE,
        S_NBRD, S_NBWR, S_TRSTEP, S_TRWR, S_FIN
    } state_t;

    state_t          state_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [4:0]      target_x_reg, target_y_reg;
    logic            out_valid_reg, out_found_reg;
    logic [2:0]      out_dir_reg;
    logic            pend_found_reg;
    logic [2:0]      pend_dir_reg;
    logic [AW-1:0]   op_idx_reg, start_idx_reg, pipe_idx_reg, best_idx_reg, cur_idx_reg;
    logic            op_free_reg;
    logic [CW-1:0]   start_cost_reg;
    logic            pipe_vld_reg, any_reg;
    logic [XW-1:0]   rx_reg, pipe_x_reg, bx_reg;
    logic [YW-1:0]   ry_reg, pipe_y_reg, by_reg;
    word_t           best_word_reg;
    logic [1:0]      nb_reg, cur_pdir_reg;

    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [DW-1:0]   wr_data, rd_data;
    word_t           rd_word, wmod;

    logic            in_range;
    logic [AW-1:0]   in_idx;
    logic [CW-1:0]   in_cost;
    logic            nb_ok;
    logic [XW-1:0]   nb_x;
    logic [YW-1:0]   nb_y;
    logic [AW-1:0]   nb_idx;
    logic [CW-1:0]   nb_cost;
    logic [AW-1:0]   par_idx;
    logic [2:0]      par_dir;
    logic            best_is_target;
    logic            cfg_wr;

    function automatic logic [PW-1:0] absdiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [CW-1:0] tile_dist(input logic [PW-1:0] x,
                                                input logic [PW-1:0] y,
                                                input logic [4:0] tx, input logic [4:0] ty);
        logic [PW:0] s;
        s = {1'b0, absdiff(x, PW'(tx))} + {1'b0, absdiff(y, PW'(ty))};
        tile_dist = CW'(s);
    endfunction

    assign rd_word = word_t'(rd_data);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {27'd0, target_y_reg} : {27'd0, target_x_reg};

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign direction  = out_dir_reg;
    assign path_found = out_found_reg;

    always_comb
    begin
        in_range = (int'(tile_x) < GRID_W) && (int'(tile_y) < GRID_H);
        in_idx   = AW'(AW'(tile_y) * AW'(GRID_W)) + AW'(tile_x);
        in_cost  = tile_dist(PW'(tile_x), PW'(tile_y), target_x_reg, target_y_reg);

        nb_x  = bx_reg;
        nb_y  = by_reg;
        nb_ok = 1'b0;
        nb_idx = best_idx_reg;
        case (nb_reg)
            NB_UP:
            begin
                nb_ok  = (by_reg != '0);
                nb_y   = by_reg - 1'b1;
                nb_idx = best_idx_reg - AW'(GRID_W);
            end
            NB_RIGHT:
            begin
                nb_ok  = (bx_reg != XW'(GRID_W - 1));
                nb_x   = bx_reg + 1'b1;
                nb_idx = best_idx_reg + 1'b1;
            end
            NB_DOWN:
            begin
                nb_ok  = (by_reg != YW'(GRID_H - 1));
                nb_y   = by_reg + 1'b1;
                nb_idx = best_idx_reg + AW'(GRID_W);
            end
            default:
            begin
                nb_ok  = (bx_reg != '0);
                nb_x   = bx_reg - 1'b1;
                nb_idx = best_idx_reg - 1'b1;
            end
        endcase
        nb_cost = tile_dist(PW'(nb_x), PW'(nb_y), target_x_reg, target_y_reg) + 1'b1;

        // parent lies opposite to the side the child was opened on
        case (cur_pdir_reg)
            NB_UP:
            begin
                par_idx = cur_idx_reg + AW'(GRID_W);
                par_dir = DIR_UP;
            end
            NB_RIGHT:
            begin
                par_idx = cur_idx_reg - 1'b1;
                par_dir = DIR_RIGHT;
            end
            NB_DOWN:
            begin
                par_idx = cur_idx_reg - AW'(GRID_W);
                par_dir = DIR_DOWN;
            end
            default:
            begin
                par_idx = cur_idx_reg + 1'b1;
                par_dir = DIR_LEFT;
            end
        endcase

        best_is_target = (PW'(bx_reg) == PW'(target_x_reg))
                      && (PW'(by_reg) == PW'(target_y_reg));
    end

    // memory port control; accesses are sequenced so a read and a write never hit the same entry at once
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wmod    = rd_word;
        case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wmod    = '0;
            end
            S_IDLE:
            begin
                if (in_valid && in_range && (action == ACT_WRITE || action == ACT_READ))
                begin
                    rd_en   = 1'b1;
                    rd_addr = in_idx;
                end
            end
            S_WRMOD:
            begin
                wr_en       = 1'b1;
                wr_addr     = op_idx_reg;
                wmod.free_b = op_free_reg;
            end
            S_SCLR:
            begin
                if (int'(cnt_reg) < N)
                begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_reg[AW-1:0];
                end
                if (pipe_vld_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pipe_idx_reg;
                    wmod.closed_b = 1'b0;
                    wmod.open_b   = (pipe_idx_reg == start_idx_reg);
                    if (pipe_idx_reg == start_idx_reg)
                    begin
                        wmod.cost = start_cost_reg;
                    end
                end
            end
            S_SCAN:
            begin
                if (int'(cnt_reg) < N)
                begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_reg[AW-1:0];
                end
            end
            S_CLOSE:
            begin
                wr_en         = 1'b1;
                wr_addr       = best_idx_reg;
                wmod          = best_word_reg;
                wmod.open_b   = 1'b0;
                wmod.closed_b = 1'b1;
            end
            S_NBRD:
            begin
                if (nb_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = nb_idx;
                end
            end
            S_NBWR:
            begin
                if (rd_word.free_b && !rd_word.open_b && !rd_word.closed_b)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = nb_idx;
                    wmod.open_b = 1'b1;
                    wmod.cost   = nb_cost;
                    wmod.pdir   = nb_reg;
                end
            end
            S_TRSTEP:
            begin
                if (cur_idx_reg != start_idx_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = par_idx;
                end
            end
            S_TRWR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cur_idx_reg;
                wmod.dir = pend_dir_reg;
            end
            default:
            begin
            end
        endcase
        wr_data = DW'(wmod);
    end

    gps_tile_ram #(
        .DEPTH (N),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_dir_reg    <= DIR_NONE;
            pend_found_reg <= 1'b0;
            pend_dir_reg   <= DIR_NONE;
            pipe_vld_reg   <= 1'b0;
            any_reg        <= 1'b0;
            nb_reg         <= NB_UP;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2])
                begin
                    target_y_reg <= pwdata[4:0];
                end
                else
                begin
                    target_x_reg <= pwdata[4:0];
                end
            end

            // the finish step reloads the result register itself
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (int'(cnt_reg) == N - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pend_found_reg <= 1'b0;
                        pend_dir_reg   <= DIR_NONE;
                        op_idx_reg     <= in_idx;
                        op_free_reg    <= is_free;
                        unique case (action)
                            ACT_WRITE:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_WRMOD;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            ACT_SEARCH:
                            begin
                                if (in_range)
                                begin
                                    start_idx_reg  <= in_idx;
                                    start_cost_reg <= in_cost;
                                    cnt_reg        <= '0;
                                    pipe_vld_reg   <= 1'b0;
                                    state_reg      <= S_SCLR;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            ACT_READ:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_RDDIR;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_WRMOD:
                begin
                    state_reg <= S_FIN;
                end
                S_RDDIR:
                begin
                    pend_dir_reg <= rd_word.dir;
                    state_reg    <= S_FIN;
                end
                S_SCLR:
                begin
                    pipe_vld_reg <= (int'(cnt_reg) < N);
                    pipe_idx_reg <= cnt_reg[AW-1:0];
                    if (int'(cnt_reg) < N)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (!pipe_vld_reg)
                    begin
                        cnt_reg   <= '0;
                        rx_reg    <= '0;
                        ry_reg    <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pipe_vld_reg <= (int'(cnt_reg) < N);
                    pipe_idx_reg <= cnt_reg[AW-1:0];
                    pipe_x_reg   <= rx_reg;
                    pipe_y_reg   <= ry_reg;
                    if (int'(cnt_reg) < N)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (rx_reg == XW'(GRID_W - 1))
                        begin
                            rx_reg <= '0;
                            ry_reg <= ry_reg + 1'b1;
                        end
                        else
                        begin
                            rx_reg <= rx_reg + 1'b1;
                        end
                    end
                    // strict compare keeps the first tile in scan order on ties
                    if (pipe_vld_reg && rd_word.open_b
                        && (!any_reg || rd_word.cost < best_word_reg.cost))
                    begin
                        best_word_reg <= rd_word;
                        best_idx_reg  <= pipe_idx_reg;
                        bx_reg        <= pipe_x_reg;
                        by_reg        <= pipe_y_reg;
                        any_reg       <= 1'b1;
                    end
                    if (int'(cnt_reg) == N && !pipe_vld_reg)
                    begin
                        if (!any_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (best_is_target)
                        begin
                            cur_idx_reg  <= best_idx_reg;
                            cur_pdir_reg <= best_word_reg.pdir;
                            state_reg    <= S_TRSTEP;
                        end
                        else
                        begin
                            state_reg <= S_CLOSE;
                        end
                    end
                end
                S_CLOSE:
                begin
                    nb_reg    <= NB_UP;
                    state_reg <= S_NBRD;
                end
                S_NBRD:
                begin
                    if (nb_ok)
                    begin
                        state_reg <= S_NBWR;
                    end
                    else if (nb_reg == NB_LEFT)
                    begin
                        cnt_reg      <= '0;
                        rx_reg       <= '0;
                        ry_reg       <= '0;
                        any_reg      <= 1'b0;
                        pipe_vld_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        nb_reg <= nb_reg + 1'b1;
                    end
                end
                S_NBWR:
                begin
                    if (nb_reg == NB_LEFT)
                    begin
                        cnt_reg      <= '0;
                        rx_reg       <= '0;
                        ry_reg       <= '0;
                        any_reg      <= 1'b0;
                        pipe_vld_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        nb_reg    <= nb_reg + 1'b1;
                        state_reg <= S_NBRD;
                    end
                end
                S_TRSTEP:
                begin
                    if (cur_idx_reg == start_idx_reg)
                    begin
                        pend_found_reg <= 1'b1;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        cur_idx_reg  <= par_idx;
                        pend_dir_reg <= par_dir;
                        state_reg    <= S_TRWR;
                    end
                end
                S_TRWR:
                begin
                    cur_pdir_reg <= rd_word.pdir;
                    pend_dir_reg <= DIR_NONE;
                    state_reg    <= S_TRSTEP;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dir_reg   <= pend_dir_reg;
                        out_found_reg <= pend_found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("tile memory read and write hit the same entry");

    a_found_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |-> (out_dir_reg == DIR_NONE))
        else $error("search result carries a direction");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside the finish step");

    a_trace_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRWR) |-> $past(state_reg == S_TRSTEP))
        else $error("trace write without a preceding parent read");
`endif

endmodule

FILE: rtl/gps_tile_ram.sv
// Tile record memory: one write port, one registered read port.
module gps_tile_ram
    import gps_pkg::*;
#(
    parameter int DEPTH = GRID_W_DEF * GRID_H_DEF,
    parameter int DW    = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
